// ----- rtl/core/alias_table_sampler_top_defines.svh -----
// ----------------------------------------------------------------------------
// Alias table sampler assertion macros
// Shared property shorthands for the checker of the sampler's ports.
// ----------------------------------------------------------------------------
`ifndef ALIAS_TABLE_SAMPLER_TOP_DEFINES_SVH
`define ALIAS_TABLE_SAMPLER_TOP_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define ATS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, ignored while reset is asserted.
`define ATS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define ATS_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/ats_pkg.sv -----
// ----------------------------------------------------------------------------
// Alias table sampler package
// Transaction payload types and command and result codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ats_pkg;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic KIND_BUILD  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  localparam int INDEX_W = 10;

  typedef struct packed {
    logic        command;
    logic [15:0] weight;
    logic        last;
    logic [31:0] column_random;
    logic [31:0] threshold_random;
  } req_item_t;

  typedef struct packed {
    logic               kind;
    logic [INDEX_W-1:0] index;
    logic               error;
  } rsp_item_t;

endpackage

// ----- rtl/core/alias_table_sampler_top.sv -----
// ----------------------------------------------------------------------------
// Alias table sampler
// Exact-integer alias method: weight loading, table build and sampling.
// ----------------------------------------------------------------------------
// Usage: transactions arrive on the req channel (req_valid, req_stall, req)
// and results leave on the rsp channel (rsp_valid, rsp_stall, rsp).
// A load transaction stores one weight while there is room and gives no
// result unless it is marked last. The last load starts a table build over
// the n stored entries: a classify pass, small/large pairings (at most n
// pairings) and a leftover pass. A build result (kind 0) follows the build;
// if n or the sum is zero, no build runs and the result flags an error.
// A sample passes through a column multiply as it is accepted, one read of
// the table memory (ST_SMP_RD) and the threshold compare (ST_SMP_CMP); its
// result is then placed in the output register (ST_EMIT) once that is free.
// The block works on one transaction at a time and holds req_stall high while
// busy, so it accepts no new transaction before the result is placed; the
// next transaction may be accepted while the previous result still waits
// in the output register.
// Reset is synchronous; it empties the table and the output register.
// Memories need no clearing pass. When rsp_stall is high the result holds
// and the block waits before placing the next one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module alias_table_sampler_top
  import ats_pkg::*;
#(
  parameter int MAX_ENTRIES = 1024,
  parameter int WEIGHT_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_item_t rsp
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = IDX_W + 1;
  localparam int P_W   = WEIGHT_BITS + CNT_W;   // scaled weights and the sum
  localparam int SE_W  = P_W + IDX_W;           // stack entry {value, id}
  localparam int TE_W  = P_W + IDX_W;           // table entry {threshold, alias}

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_CLASSIFY = 8'b0000_0010,
    ST_PAIR_RD  = 8'b0000_0100,
    ST_PAIR_EX  = 8'b0000_1000,
    ST_LEFT     = 8'b0001_0000,
    ST_SMP_RD   = 8'b0010_0000,
    ST_SMP_CMP  = 8'b0100_0000,
    ST_EMIT     = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  // Architectural state.
  logic [CNT_W-1:0] entry_count;
  logic [P_W-1:0]   weight_sum;
  logic             table_valid;
  logic [CNT_W-1:0] small_count;
  logic [CNT_W-1:0] large_count;

  // Pending result and output register.
  rsp_item_t res;

  // Classify pipeline.
  logic [CNT_W-1:0] ci;
  logic             c_v1, c_v2;
  logic [IDX_W-1:0] c_id1, c_id2;
  logic [P_W-1:0]   c_p2;

  // Leftover pipeline.
  logic [CNT_W-1:0] li;
  logic             l_v, l_src;

  // Sample pipeline.
  logic [IDX_W-1:0] s_col;
  logic [31+P_W:0]  s_vs;

  // Memory ports.
  logic             w_we;
  logic [IDX_W-1:0] w_waddr, w_raddr;
  logic [WEIGHT_BITS-1:0] w_wdata, w_rdata;
  logic             sm_we, lg_we, t_we;
  logic [IDX_W-1:0] sm_waddr, sm_raddr, lg_waddr, lg_raddr, t_waddr, t_raddr;
  logic [SE_W-1:0]  sm_wdata, sm_rdata, lg_wdata, lg_rdata;
  logic [TE_W-1:0]  t_wdata, t_rdata;

  logic req_acc;
  logic out_free;

  // Load bookkeeping: a load after a valid table starts a fresh set.
  logic [CNT_W-1:0] eff_cnt, new_cnt;
  logic [P_W-1:0]   eff_sum, new_sum;
  logic             room;
  logic [WEIGHT_BITS+15:0] wt_wide;

  // Pairing arithmetic.
  logic [P_W-1:0]   sm_p, lg_p;
  logic [IDX_W-1:0] sm_id, lg_id;
  logic [P_W:0]     np_wide;
  logic [P_W-1:0]   np;
  logic             np_large;
  logic [CNT_W-1:0] sc_after, lc_after;

  // Leftover and sample helpers.
  logic [SE_W-1:0]  l_entry;
  logic [31+CNT_W:0] col_prod;
  logic [IDX_W-1:0] pick;
  logic [IDX_W+9:0] pick_wide;
  logic             classify_done, left_done;
  logic [CNT_W-1:0] left_total;

  assign req_acc   = req_valid && !req_stall;
  assign req_stall = (state != ST_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;

  assign wt_wide = {{WEIGHT_BITS{1'b0}}, req.weight};
  assign eff_cnt = table_valid ? '0 : entry_count;
  assign eff_sum = table_valid ? '0 : weight_sum;
  assign room    = (eff_cnt < CNT_W'(MAX_ENTRIES));
  assign new_cnt = room ? eff_cnt + 1'b1 : eff_cnt;
  assign new_sum = room ? eff_sum + P_W'(wt_wide[WEIGHT_BITS-1:0]) : eff_sum;

  assign sm_p  = sm_rdata[SE_W-1:IDX_W];
  assign sm_id = sm_rdata[IDX_W-1:0];
  assign lg_p  = lg_rdata[SE_W-1:IDX_W];
  assign lg_id = lg_rdata[IDX_W-1:0];
  // lg_p is at least the sum, so this never goes negative.
  assign np_wide  = {1'b0, sm_p} + {1'b0, lg_p} - {1'b0, weight_sum};
  assign np       = np_wide[P_W-1:0];
  assign np_large = (np >= weight_sum);
  assign sc_after = np_large ? small_count - 1'b1 : small_count;
  assign lc_after = np_large ? large_count : large_count - 1'b1;

  assign l_entry    = l_src ? lg_rdata : sm_rdata;
  assign left_total = small_count + large_count;
  assign classify_done = (ci == entry_count) && !c_v1 && !c_v2;
  assign left_done     = (li == left_total) && !l_v;

  assign col_prod = (32 + CNT_W)'(req.column_random) * (32 + CNT_W)'(entry_count);

  // The threshold is scaled so that the sum stands for probability one.
  assign pick = (s_vs > {t_rdata[TE_W-1:IDX_W], 32'b0}) ? t_rdata[IDX_W-1:0] : s_col;
  assign pick_wide = {10'b0, pick};

  // Memory port steering.
  always_comb begin
    w_we     = req_acc && (req.command == CMD_LOAD) && room;
    w_waddr  = eff_cnt[IDX_W-1:0];
    w_wdata  = wt_wide[WEIGHT_BITS-1:0];
    w_raddr  = ci[IDX_W-1:0];

    sm_we    = 1'b0;
    sm_waddr = small_count[IDX_W-1:0];
    sm_wdata = {c_p2, c_id2};
    lg_we    = 1'b0;
    lg_waddr = large_count[IDX_W-1:0];
    lg_wdata = {c_p2, c_id2};
    sm_raddr = '0;
    lg_raddr = '0;

    t_we     = 1'b0;
    t_waddr  = sm_id;
    t_wdata  = {sm_p, lg_id};
    t_raddr  = s_col;

    case (state)
      ST_CLASSIFY: begin
        if (c_v2) begin
          if (c_p2 < weight_sum) begin
            sm_we = 1'b1;
          end else begin
            lg_we = 1'b1;
          end
        end
      end
      ST_PAIR_RD: begin
        sm_raddr = IDX_W'(small_count - 1'b1);
        lg_raddr = IDX_W'(large_count - 1'b1);
      end
      ST_PAIR_EX: begin
        t_we = 1'b1;
        if (np_large) begin
          lg_we    = 1'b1;
          lg_waddr = IDX_W'(large_count - 1'b1);
          lg_wdata = {np, lg_id};
        end else begin
          sm_we    = 1'b1;
          sm_waddr = IDX_W'(small_count - 1'b1);
          sm_wdata = {np, lg_id};
        end
      end
      ST_LEFT: begin
        sm_raddr = li[IDX_W-1:0];
        lg_raddr = IDX_W'(li - small_count);
        if (l_v) begin
          t_we    = 1'b1;
          t_waddr = l_entry[IDX_W-1:0];
          t_wdata = {weight_sum, l_entry[IDX_W-1:0]};
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_acc) begin
          if (req.command == CMD_LOAD) begin
            if (req.last) begin
              state_next = (new_cnt == '0 || new_sum == '0) ? ST_EMIT : ST_CLASSIFY;
            end
          end else if (!table_valid || entry_count == '0) begin
            state_next = ST_EMIT;
          end else begin
            state_next = ST_SMP_RD;
          end
        end
      end
      ST_CLASSIFY: begin
        if (classify_done) begin
          state_next = (small_count != '0 && large_count != '0) ? ST_PAIR_RD : ST_LEFT;
        end
      end
      ST_PAIR_RD: state_next = ST_PAIR_EX;
      ST_PAIR_EX: begin
        state_next = (sc_after != '0 && lc_after != '0) ? ST_PAIR_RD : ST_LEFT;
      end
      ST_LEFT: begin
        if (left_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_SMP_RD:  state_next = ST_SMP_CMP;
      ST_SMP_CMP: state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
      weight_sum  <= '0;
      table_valid <= 1'b0;
      small_count <= '0;
      large_count <= '0;
      rsp_valid   <= 1'b0;
      c_v1        <= 1'b0;
      c_v2        <= 1'b0;
      l_v         <= 1'b0;
    end else begin
      state <= state_next;

      // A new result is placed when the register is free; an accepted one leaves.
      if (state == ST_EMIT && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (req_acc) begin
            if (req.command == CMD_LOAD) begin
              table_valid <= 1'b0;
              res.kind    <= KIND_BUILD;
              res.index   <= '0;
              if (req.last && (new_cnt == '0 || new_sum == '0)) begin
                entry_count <= '0;
                weight_sum  <= '0;
                res.error   <= 1'b1;
              end else begin
                entry_count <= new_cnt;
                weight_sum  <= new_sum;
                res.error   <= 1'b0;
              end
              ci          <= '0;
              small_count <= '0;
              large_count <= '0;
            end else begin
              res.kind  <= KIND_SAMPLE;
              res.index <= '0;
              res.error <= !table_valid || entry_count == '0;
              s_col     <= col_prod[31+IDX_W:32];
              s_vs      <= (32 + P_W)'(req.threshold_random) * (32 + P_W)'(weight_sum);
            end
          end
        end
        ST_CLASSIFY: begin
          c_v1  <= (ci != entry_count);
          c_id1 <= ci[IDX_W-1:0];
          if (ci != entry_count) begin
            ci <= ci + 1'b1;
          end
          c_v2  <= c_v1;
          c_id2 <= c_id1;
          c_p2  <= P_W'(w_rdata) * P_W'(entry_count);
          if (c_v2) begin
            if (c_p2 < weight_sum) begin
              small_count <= small_count + 1'b1;
            end else begin
              large_count <= large_count + 1'b1;
            end
          end
          li <= '0;
        end
        ST_PAIR_EX: begin
          small_count <= sc_after;
          large_count <= lc_after;
        end
        ST_LEFT: begin
          l_v   <= (li != left_total);
          l_src <= (li >= small_count);
          if (li != left_total) begin
            li <= li + 1'b1;
          end
          if (left_done) begin
            table_valid <= 1'b1;
          end
        end
        ST_SMP_CMP: begin
          res.index <= pick_wide[9:0];
        end
        ST_EMIT: begin
          if (out_free) begin
            rsp <= res;
          end
        end
        default: begin
        end
      endcase
    end
  end

  ats_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_ENTRIES)) u_weight_ram (
    .clk(clk), .wr_en(w_we), .wr_addr(w_waddr), .wr_data(w_wdata),
    .rd_addr(w_raddr), .rd_data(w_rdata)
  );

  ats_ram #(.WIDTH(SE_W), .DEPTH(MAX_ENTRIES)) u_small_ram (
    .clk(clk), .wr_en(sm_we), .wr_addr(sm_waddr), .wr_data(sm_wdata),
    .rd_addr(sm_raddr), .rd_data(sm_rdata)
  );

  ats_ram #(.WIDTH(SE_W), .DEPTH(MAX_ENTRIES)) u_large_ram (
    .clk(clk), .wr_en(lg_we), .wr_addr(lg_waddr), .wr_data(lg_wdata),
    .rd_addr(lg_raddr), .rd_data(lg_rdata)
  );

  ats_ram #(.WIDTH(TE_W), .DEPTH(MAX_ENTRIES)) u_table_ram (
    .clk(clk), .wr_en(t_we), .wr_addr(t_waddr), .wr_data(t_wdata),
    .rd_addr(t_raddr), .rd_data(t_rdata)
  );

endmodule

// ----- rtl/core/ats_ram.sv -----
// ----------------------------------------------------------------------------
// Alias table sampler RAM
// Simple dual-port synchronous memory, one write and one registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ats_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/core/ats_checker.sv -----
// ----------------------------------------------------------------------------
// Alias table sampler checker
// Port-level properties of the sampler, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "alias_table_sampler_top_defines.svh"

module ats_checker
  import ats_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      rsp_valid,
  input logic      rsp_stall,
  input rsp_item_t rsp
);

  `ATS_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
  `ATS_ASSERT_RST(a_rsp_reset, rst, !rsp_valid)
  `ATS_ASSERT_IMP(a_build_index, rsp_valid && rsp.kind == KIND_BUILD, rsp.index == '0)
  `ATS_ASSERT_IMP(a_err_index, rsp_valid && rsp.error, rsp.index == '0)

endmodule

bind alias_table_sampler_top ats_checker u_ats_checker (
  .clk(clk),
  .rst(rst),
  .rsp_valid(rsp_valid),
  .rsp_stall(rsp_stall),
  .rsp(rsp)
);

// ----- verif/alias_table_sampler_top_tb.sv -----
// ----------------------------------------------------------------------------
// Alias table sampler testbench
// Loads weight sets, builds alias tables and draws samples. An internal
// table builder predicts every build and sample result, and a monitor
// compares each result transaction with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module alias_table_sampler_top_tb;
  import ats_pkg::*;

  localparam int NMAX = 1024;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  req_item_t req = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_item_t rsp;

  alias_table_sampler_top dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall),
    .req(req), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always #6 clk = ~clk;

  // Shadow of the sampler state. Thresholds are held as 64-bit integers in
  // units where the weight sum stands for probability one.
  logic [15:0] shadow_weight [NMAX];
  logic [63:0] shadow_thresh [NMAX];
  logic [9:0]  shadow_alias [NMAX];
  int unsigned shadow_count;
  logic [63:0] shadow_sum;
  bit          shadow_valid;

  req_item_t pending_reqs[$];
  rsp_item_t expected_rsps[$];
  int        fail_count = 0;
  bit        stim_done = 1'b0;
  bit        quiet_phase = 1'b0;
  bit        hold_rsp = 1'b0;

  // Vose pairing over the loaded weights, in exact integers.
  task automatic build_alias_table();
    logic [63:0] sp [NMAX];
    logic [63:0] lp [NMAX];
    int          sid [NMAX];
    int          lid [NMAX];
    int          ns, nl;
    logic [63:0] scaled, merged;
    ns = 0;
    nl = 0;
    for (int i = 0; i < shadow_count; i++) begin
      scaled = 64'(shadow_weight[i]) * 64'(shadow_count);
      if (scaled < shadow_sum) begin
        sp[ns] = scaled; sid[ns] = i; ns++;
      end else begin
        lp[nl] = scaled; lid[nl] = i; nl++;
      end
    end
    while (ns > 0 && nl > 0) begin
      shadow_thresh[sid[ns-1]] = sp[ns-1];
      shadow_alias[sid[ns-1]] = 10'(lid[nl-1]);
      merged = sp[ns-1] + lp[nl-1] - shadow_sum;
      if (merged >= shadow_sum) begin
        lp[nl-1] = merged;
        ns--;
      end else begin
        sp[ns-1] = merged; sid[ns-1] = lid[nl-1];
        nl--;
      end
    end
    for (int i = 0; i < ns; i++) begin
      shadow_thresh[sid[i]] = shadow_sum; shadow_alias[sid[i]] = 10'(sid[i]);
    end
    for (int i = 0; i < nl; i++) begin
      shadow_thresh[lid[i]] = shadow_sum; shadow_alias[lid[i]] = 10'(lid[i]);
    end
  endtask

  // Updates the shadow state for one accepted transaction and queues the
  // result it should cause, if any.
  task automatic predict_result(input req_item_t t);
    rsp_item_t   r;
    logic [63:0] col;
    r = '0;
    if (t.command == CMD_LOAD) begin
      if (shadow_valid) begin
        shadow_valid = 1'b0; shadow_count = 0; shadow_sum = 0;
      end
      if (shadow_count < NMAX) begin
        shadow_weight[shadow_count] = t.weight;
        shadow_count++;
        shadow_sum += 64'(t.weight);
      end
      if (!t.last) return;
      r.kind = KIND_BUILD;
      if (shadow_count == 0 || shadow_sum == 0) begin
        shadow_count = 0; shadow_sum = 0; r.error = 1'b1;
      end else begin
        build_alias_table();
        shadow_valid = 1'b1;
      end
    end else begin
      r.kind = KIND_SAMPLE;
      if (!shadow_valid || shadow_count == 0) begin
        r.error = 1'b1;
      end else begin
        col = (64'(t.column_random) * 64'(shadow_count)) >> 32;
        if (col >= NMAX) col = 64'(NMAX - 1);
        if (64'(t.threshold_random) * shadow_sum > (shadow_thresh[col] << 32))
          r.index = shadow_alias[col];
        else
          r.index = col[9:0];
      end
    end
    expected_rsps.push_back(r);
  endtask

  // Driver: offers queued transactions, with random idle bursts.
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) predict_result(req);
      if (req_valid && req_stall) begin
        // A stalled transaction stays on the bus unchanged.
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        req_valid <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 19) == 0) begin
        send_gap <= $urandom_range(1, 18);
        req_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req <= pending_reqs.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: random bursts, or a long hold when requested.
  int rsp_gap = 0;
  int hold_cnt = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (hold_rsp && !hold_done) begin
      rsp_stall <= 1'b1;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt == 299) hold_done <= 1'b1;
    end else if (rsp_gap > 0) begin
      rsp_gap <= rsp_gap - 1;
      rsp_stall <= 1'b1;
    end else if (!quiet_phase && $urandom_range(0, 15) == 0) begin
      rsp_gap <= $urandom_range(1, 18);
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // Monitor: each accepted result against the oldest prediction.
  always @(posedge clk) begin
    rsp_item_t e;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected result kind=%0d index=%0d error=%0d",
                 $time, rsp.kind, rsp.index, rsp.error);
        fail_count++;
      end else begin
        e = expected_rsps.pop_front();
        if (rsp.kind !== e.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, e.kind, rsp.kind);
          fail_count++;
        end
        if (rsp.index !== e.index) begin
          $display("%0t: index expected %0d actual %0d", $time, e.index, rsp.index);
          fail_count++;
        end
        if (rsp.error !== e.error) begin
          $display("%0t: error expected %0d actual %0d", $time, e.error, rsp.error);
          fail_count++;
        end
      end
    end
  end

  function automatic req_item_t make_load(input logic [15:0] w, input logic lst);
    req_item_t t;
    t = '0;
    t.command = CMD_LOAD;
    t.weight = w;
    t.last = lst;
    t.column_random = $urandom();
    t.threshold_random = $urandom();
    return t;
  endfunction

  function automatic req_item_t make_sample(input logic [31:0] u, input logic [31:0] v);
    req_item_t t;
    t = '0;
    t.command = CMD_SAMPLE;
    t.weight = 16'($urandom());
    t.last = 1'($urandom());
    t.column_random = u;
    t.threshold_random = v;
    return t;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
      @(posedge clk);
  endtask

  // Queues one weight set of the given size with mixed weight shapes.
  task automatic queue_weight_set(input int n);
    int mode;
    logic [15:0] w;
    mode = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: w = 16'($urandom());
        1: w = 16'($urandom_range(0, 3));
        2: w = ($urandom_range(0, 4) == 0) ? 16'hFFFF : 16'(($urandom_range(0, 9)));
        default: w = ($urandom_range(0, 1)) ? 16'hFFFF : 16'h0000;
      endcase
      pending_reqs.push_back(make_load(w, i == n - 1));
    end
  endtask

  task automatic queue_samples(input int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: pending_reqs.push_back(make_sample(32'hFFFFFFFF, $urandom()));
        1: pending_reqs.push_back(make_sample($urandom(), 32'hFFFFFFFF));
        2: pending_reqs.push_back(make_sample($urandom(), 32'h0));
        default: pending_reqs.push_back(make_sample($urandom(), $urandom()));
      endcase
    end
  endtask

  initial begin
    int sent;
    shadow_count = 0;
    shadow_sum = 0;
    shadow_valid = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part: sample before any build, empty sums, extremes, one entry.
    pending_reqs.push_back(make_sample(32'h0, 32'h0));
    pending_reqs.push_back(make_load(16'h0, 1'b1));
    pending_reqs.push_back(make_load(16'h0, 1'b0));
    pending_reqs.push_back(make_load(16'h0, 1'b1));
    pending_reqs.push_back(make_sample(32'hFFFFFFFF, 32'hFFFFFFFF));
    pending_reqs.push_back(make_load(16'hFFFF, 1'b1));
    pending_reqs.push_back(make_sample(32'hFFFFFFFF, 32'hFFFFFFFF));
    pending_reqs.push_back(make_sample(32'h0, 32'h0));
    pending_reqs.push_back(make_load(16'h0001, 1'b0));
    pending_reqs.push_back(make_load(16'hFFFF, 1'b0));
    pending_reqs.push_back(make_load(16'h5555, 1'b0));
    pending_reqs.push_back(make_load(16'hAAAA, 1'b1));
    pending_reqs.push_back(make_sample(32'h0, 32'hFFFFFFFF));
    pending_reqs.push_back(make_sample(32'hFFFFFFFF, 32'h0));
    pending_reqs.push_back(make_sample(32'h7FFFFFFF, 32'h80000000));
    pending_reqs.push_back(make_sample(32'hC0000000, 32'hFFFFFFFF));
    wait_drained();

    // Fill the table beyond its capacity once, with extreme weights.
    for (int i = 0; i < NMAX + 3; i++)
      pending_reqs.push_back(make_load((i % 3 == 0) ? 16'hFFFF : 16'(i), i == NMAX + 2));
    queue_samples(6);
    wait_drained();

    // Long receiver hold while the sender keeps offering samples.
    queue_weight_set(5);
    queue_samples(30);
    hold_rsp = 1'b1;
    wait (hold_done);
    hold_rsp = 1'b0;
    wait_drained();

    // Random part: mostly weight sets followed by samples, some noise.
    sent = 0;
    while (sent < 250) begin
      int n, k;
      if (sent > 190) quiet_phase = 1'b1;
      case ($urandom_range(0, 9))
        0: begin
          queue_samples(2); sent += 2;
        end
        1: begin
          pending_reqs.push_back(make_load(16'($urandom_range(0, 1)), 1'b1)); sent++;
        end
        default: begin
          n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 8);
          k = $urandom_range(3, 20);
          queue_weight_set(n);
          queue_samples(k);
          sent += n + k;
        end
      endcase
      if ($urandom_range(0, 7) == 0) wait_drained();
      while (pending_reqs.size() > 40) @(posedge clk);
    end
    wait_drained();
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #40ms;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/ats_pkg.sv
rtl/core/ats_ram.sv
rtl/core/alias_table_sampler_top.sv
rtl/core/ats_checker.sv
verif/alias_table_sampler_top_tb.sv
